// ===== hw/rtl/itoa_pkg.sv =====
`default_nettype none

package itoa_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int DEC_DIGITS = (WORD_WIDTH * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (WORD_WIDTH + 3) / 4;
  localparam int SHIFT_W    = 4 * DEC_DIGITS;
  localparam int CNT_W      = $clog2(WORD_WIDTH + 1);

  typedef logic [2:0]            op_t;
  typedef logic [7:0]            char_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  localparam op_t OP_SDEC    = 3'd0;
  localparam op_t OP_UDEC    = 3'd1;
  localparam op_t OP_CHAR    = 3'd2;
  localparam op_t OP_HEX     = 3'd3;
  localparam op_t OP_BIN     = 3'd4;
  localparam op_t OP_PERCENT = 3'd5;

  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_ONE   = 8'h31;
  localparam char_t CH_MINUS = 8'h2d;
  localparam char_t CH_LC_A  = 8'h61;
  localparam char_t CH_LC_B  = 8'h62;
  localparam char_t CH_LC_X  = 8'h78;
  localparam char_t CH_PCT   = 8'h25;

  function automatic char_t hex_char(input logic [3:0] d);
    char_t c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'h0, d};
    end else begin
      c = CH_LC_A + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itoa_if.sv =====
`default_nettype none

interface itoa_in_if;
  logic                valid;
  logic                ready;
  itoa_pkg::op_t       op;
  logic [itoa_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface itoa_out_if;
  logic            valid;
  logic            ready;
  itoa_pkg::char_t ch;
  logic            last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/integer_to_ascii_formatter_unit.sv =====
`default_nettype none

// channel   dir  beat            payload
// in_if     in   one argument    op, value
// out_if    out  one character   ch, last
//
// decimal: shift-add-3 conversion in the shared bcd shifter, then leading zero digits
//   are dropped, keeping at least one digit, then the characters are emitted
// hex/binary: leading zero digits are dropped, keeping at least one, then the characters are emitted
// char/percent: one character; in_if is ready only between items
// reset clears the sequencer and the output valid flag; out_if stalls hold the
//   sequencer, and a new item is taken while the final character still waits

module integer_to_ascii_formatter_unit (
  input  wire        clk,
  input  wire        rst_n,
  itoa_in_if.sink    in_if,
  itoa_out_if.source out_if
);

  localparam int WW = itoa_pkg::WORD_WIDTH;
  localparam int SW = itoa_pkg::SHIFT_W;
  localparam int ND = itoa_pkg::DEC_DIGITS;
  localparam int CW = itoa_pkg::CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SKIP  = 3'd2;
  localparam logic [2:0] S_MINUS = 3'd3;
  localparam logic [2:0] S_PRE0  = 3'd4;
  localparam logic [2:0] S_PRE1  = 3'd5;
  localparam logic [2:0] S_DIG   = 3'd6;
  localparam logic [2:0] S_ONE   = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [SW-1:0]         sr_r, sr_nxt;
  itoa_pkg::word_t       bin_r, bin_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  dec_r, dec_nxt;
  logic                  bmode_r, bmode_nxt;
  itoa_pkg::char_t       chr_r, chr_nxt;
  logic                  ov_r, ov_nxt;
  itoa_pkg::char_t       och_r, och_nxt;
  logic                  olast_r, olast_nxt;

  logic [WW+itoa_pkg::VALUE_W-1:0] value_ext;
  itoa_pkg::word_t       w, mag;
  logic                  neg_in;
  logic [SW-1:0]         dd, dd_sh, sr_shift;
  logic [3:0]            dig4;
  logic                  top_zero;
  itoa_pkg::char_t       dig_char;
  logic                  can_emit;

  assign value_ext = {{WW{1'b0}}, in_if.value};
  assign w         = value_ext[WW-1:0];
  assign neg_in    = (in_if.op == itoa_pkg::OP_SDEC) && w[WW-1];
  assign mag       = neg_in ? (~w + 1'b1) : w;

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (sr_r[4*i +: 4] >= 4'd5) begin
        dd[4*i +: 4] = sr_r[4*i +: 4] + 4'd3;
      end else begin
        dd[4*i +: 4] = sr_r[4*i +: 4];
      end
    end
  end

  assign dd_sh    = {dd[SW-2:0], bin_r[WW-1]};
  assign dig4     = sr_r[SW-1 -: 4];
  assign top_zero = bmode_r ? !sr_r[SW-1] : (dig4 == 4'd0);
  assign sr_shift = bmode_r ? (sr_r << 1) : (sr_r << 4);
  assign dig_char = bmode_r ? (sr_r[SW-1] ? itoa_pkg::CH_ONE : itoa_pkg::CH_ZERO)
                            : itoa_pkg::hex_char(dig4);
  assign can_emit = !ov_r || out_if.ready;

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = ov_r;
  assign out_if.ch    = och_r;
  assign out_if.last  = olast_r;

  always_comb begin
    state_nxt = state_r;
    sr_nxt    = sr_r;
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    dec_nxt   = dec_r;
    bmode_nxt = bmode_r;
    chr_nxt   = chr_r;
    ov_nxt    = ov_r && !out_if.ready;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          neg_nxt   = neg_in;
          dec_nxt   = 1'b0;
          bmode_nxt = 1'b0;
          case (in_if.op)
            itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC: begin
              dec_nxt   = 1'b1;
              sr_nxt    = '0;
              bin_nxt   = mag;
              cnt_nxt   = CW'(WW);
              state_nxt = S_CONV;
            end
            itoa_pkg::OP_HEX: begin
              sr_nxt    = SW'(w) << (SW - 4 * itoa_pkg::HEX_DIGITS);
              cnt_nxt   = CW'(itoa_pkg::HEX_DIGITS);
              state_nxt = S_SKIP;
            end
            itoa_pkg::OP_BIN: begin
              bmode_nxt = 1'b1;
              sr_nxt    = SW'(w) << (SW - WW);
              cnt_nxt   = CW'(WW);
              state_nxt = S_SKIP;
            end
            itoa_pkg::OP_CHAR: begin
              chr_nxt   = in_if.value[7:0];
              state_nxt = S_ONE;
            end
            itoa_pkg::OP_PERCENT: begin
              chr_nxt   = itoa_pkg::CH_PCT;
              state_nxt = S_ONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CONV: begin
        sr_nxt  = dd_sh;
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = CW'(ND);
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_zero && (cnt_r > CW'(1))) begin
          sr_nxt  = sr_shift;
          cnt_nxt = cnt_r - 1'b1;
        end else if (dec_r) begin
          state_nxt = neg_r ? S_MINUS : S_DIG;
        end else begin
          state_nxt = S_PRE0;
        end
      end
      S_MINUS: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          och_nxt   = itoa_pkg::CH_MINUS;
          olast_nxt = 1'b0;
          state_nxt = S_DIG;
        end
      end
      S_PRE0: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          och_nxt   = itoa_pkg::CH_ZERO;
          olast_nxt = 1'b0;
          state_nxt = S_PRE1;
        end
      end
      S_PRE1: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          och_nxt   = bmode_r ? itoa_pkg::CH_LC_B : itoa_pkg::CH_LC_X;
          olast_nxt = 1'b0;
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          och_nxt   = dig_char;
          olast_nxt = (cnt_r == CW'(1));
          sr_nxt    = sr_shift;
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ONE: begin
        if (can_emit) begin
          ov_nxt    = 1'b1;
          och_nxt   = chr_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r    <= sr_nxt;
    bin_r   <= bin_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    dec_r   <= dec_nxt;
    bmode_r <= bmode_nxt;
    chr_r   <= chr_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
  end

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG || state_r == S_SKIP) |-> cnt_r != '0)
    else $error("digit count empty while emitting");

  a_conv_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CONV |=> (state_r == S_CONV || state_r == S_SKIP))
    else $error("conversion left to wrong state");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIG && !can_emit) |=> ($stable(sr_r) && $stable(cnt_r)))
    else $error("digit shifter moved during output stall");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.op <= itoa_pkg::OP_PERCENT) |=> !in_if.ready)
    else $error("ready after taking a valid format");

endmodule

`default_nettype wire
